// ----- rtl/core/adsr_envelope_generator_top_macros.svh -----
// ----------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Clocked property shorthands shared by the envelope core files.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_TOP_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define ADSR_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ADSR_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/adsr_pkg.sv -----
// ----------------------------------------------------------------------------
// ADSR envelope package
// Widths, command, phase and csr index codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int DAC_MAX     = 4095;
   localparam int TIME_BITS   = 20;
   localparam int CFG_TIME_W  = 20;
   localparam int TIME_W      = (TIME_BITS < CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
   localparam int LVL_W       = 16;
   localparam int TIMER_W     = 22;
   localparam int SPAN_W      = LVL_W + 1;
   localparam int DIVD_W      = TIMER_W + LVL_W;
   localparam int DIV_CNT_W   = $clog2(DIVD_W);
   localparam int MUL_A_W     = 32;
   localparam int MUL_B_W     = 16;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int FAC_W       = 17;
   localparam int FAC_ONE     = 32768;
   localparam int DAC_W       = 13;
   localparam int DAC_SAT     = 8191;
   localparam int DAC_SHIFT   = 31;
   localparam int DECAY_MIN   = 128;
   localparam int DECAY_END   = 160;
   localparam int RELEASE_END = 320;

   localparam int CMD_W       = 3;
   localparam int PHASE_W     = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_END    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MUTE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_UNMUTE = 3'd4;

   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_START   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd4;
   localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LFO     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DUAL    = 3'd7;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_EXEC  = 9'b000000010,
      S_RMUL  = 9'b000000100,
      S_RDIV  = 9'b000001000,
      S_RWAIT = 9'b000010000,
      S_DMUL1 = 9'b000100000,
      S_DMUL2 = 9'b001000000,
      S_CODE  = 9'b010000000,
      S_OUT   = 9'b100000000
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/core/adsr_mul.sv -----
// ----------------------------------------------------------------------------
// ADSR shared multiplier
// Unsigned multiplier with a registered product, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module adsr_mul import adsr_pkg::*; (
   input  logic               clock,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [MUL_P_W-1:0] product
);

   logic [MUL_P_W-1:0] product_ff;
   logic [MUL_P_W-1:0] product_in;

   assign product_in = MUL_P_W'(a) * MUL_P_W'(b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ----- rtl/core/adsr_div.sv -----
// ----------------------------------------------------------------------------
// ADSR iterative divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "adsr_envelope_generator_top_macros.svh"

module adsr_div import adsr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIVD_W-1:0]   dividend,
   input  logic [TIME_W-1:0]   divisor,
   output logic [DIVD_W-1:0]   quotient,
   output div_status_type      status
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [TIME_W-1:0]    dsr_ff, dsr_in;
   logic [TIME_W:0]      rem_sh;
   logic [TIME_W+1:0]    diff;
   logic                 take;

   assign rem_sh = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};
   assign take   = ~diff[TIME_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVD_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift one dividend bit into the remainder, subtract where it fits
         rem_in = take ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `ADSR_CHECK_NOW(a_div_no_restart, start, !busy_ff, "divider restarted while busy")
   `ADSR_CHECK_NEXT(a_div_done_idle, busy_ff && cnt_ff == '0, done_ff && !busy_ff, "divider did not finish")

endmodule

// ----- rtl/core/adsr_envelope_generator_top.sv -----
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Linear attack/decay/sustain/release envelope with a modulated DAC code.
// ----------------------------------------------------------------------------
// Each request word is one command (tick, note start, note end, mute, unmute)
// and yields exactly one response word carrying the DAC write flag, the DAC
// code, the running flag and the phase. Items are handled one at a time: the
// block takes a request, works on it and drops req_tready until the result
// sits in the output register; a waiting response stalls the next request
// only in its output step. A ramp tick runs the 38-step shift-subtract
// divider that scales elapsed time against the ramp length; other writing
// items make two passes through the shared multiplier for the DAC code, and
// items without a write go straight to the output step. There is no memory
// and no clearing pass after reset. Registers on the csr port are written at
// index 0 to 7 as listed in the package and are taken at once.
// ----------------------------------------------------------------------------
`include "adsr_envelope_generator_top_macros.svh"

module adsr_envelope_generator_top import adsr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request: tdata = delta_time[15:0], lfo_sin[31:16]; tuser = cmd[2:0]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   // response: tdata = dac_code[12:0], env_active[13], phase[16:14], zeros
   //           tuser = dac_write[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,
   output logic                  rsp_tuser,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [TIMER_W-1:0] DECAY_MIN_T   = TIMER_W'(DECAY_MIN);
   localparam logic [TIMER_W-1:0] DECAY_END_T   = TIMER_W'(DECAY_END);
   localparam logic [TIMER_W-1:0] RELEASE_END_T = TIMER_W'(RELEASE_END);
   localparam int                 RSUM_W        = DIVD_W + 2;

   // sequencer and latched request
   seq_state_type        state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff;
   logic [15:0]          dt_ff;
   logic signed [15:0]   sin_ff;

   // configuration
   logic [TIME_W-1:0]    attack_ff, attack_in;
   logic [TIME_W-1:0]    decay_ff, decay_in;
   logic [TIME_W-1:0]    release_ff, release_in;
   logic [LVL_W-1:0]     base_ff, base_in;
   logic [LVL_W-1:0]     peak_ff, peak_in;
   logic [LVL_W-1:0]     sustain_ff, sustain_in;
   logic                 lfo_en_ff, lfo_en_in;
   logic                 dual_ff, dual_in;

   // envelope state
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic                 running_ff, running_in;
   logic                 end_pending_ff, end_pending_in;
   logic                 mute_ff, mute_in;
   logic                 skip_decay_ff, skip_decay_in;
   logic                 peak_hold_ff, peak_hold_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in;
   logic [TIME_W-1:0]    target_ff, target_in;
   logic signed [SPAN_W-1:0] span_ff, span_in;
   logic [LVL_W-1:0]     level_ff, level_in;
   logic [LVL_W-1:0]     sus_run_ff, sus_run_in;

   // ramp job and result staging
   logic [LVL_W-1:0]     rend_ff, rend_in;
   logic [TIME_W-1:0]    rdur_ff, rdur_in;
   logic                 wr_ff, wr_in;
   logic [DAC_W-1:0]     code_ff, code_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_wr_ff;
   logic [DAC_W-1:0]     rsp_code_ff;
   logic                 rsp_active_ff;
   logic [PHASE_W-1:0]   rsp_phase_ff;

   // helpers
   logic                 req_accept;
   logic                 csr_accept;
   logic                 rsp_free;
   logic                 ramp_go;
   logic                 exec_wr;
   logic [TIMER_W-1:0]   dt_ext;
   logic [TIMER_W-1:0]   tsum;
   logic [TIMER_W-1:0]   tdiff;
   logic [TIMER_W-1:0]   target_ext;
   logic [TIMER_W-1:0]   decay_ext;
   logic [TIMER_W-1:0]   release_ext;
   logic signed [SPAN_W-1:0] lvl_minus_base;
   logic signed [SPAN_W-1:0] peak_minus_base;
   logic signed [SPAN_W-1:0] peak_minus_sus;
   logic [SPAN_W-1:0]    span_abs;
   logic signed [FAC_W:0] fac_full;
   logic [FAC_W-1:0]     fac;
   logic signed [RSUM_W-1:0] rsum;
   logic signed [RSUM_W-1:0] quo_s;
   logic signed [RSUM_W-1:0] rend_s;
   logic [LVL_W-1:0]     ramp_sat;
   logic [MUL_P_W-DAC_SHIFT-1:0] code_raw;
   logic [DAC_W-1:0]     code_sat;

   // shared units
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_p;
   logic                 div_start;
   logic [DIVD_W-1:0]    div_q;
   div_status_type       div_st;

   adsr_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p)
   );

   adsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_p[DIVD_W-1:0]),
      .divisor  (rdur_ff),
      .quotient (div_q),
      .status   (div_st)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == S_RDIV);

   // time and level arithmetic feeding the command decode
   assign dt_ext      = TIMER_W'(dt_ff);
   assign tsum        = timer_ff + dt_ext;
   assign tdiff       = timer_ff - dt_ext;
   assign target_ext  = TIMER_W'(target_ff);
   assign decay_ext   = TIMER_W'(decay_ff);
   assign release_ext = TIMER_W'(release_ff);

   assign lvl_minus_base  = $signed({1'b0, level_ff}) - $signed({1'b0, base_ff});
   assign peak_minus_base = $signed({1'b0, peak_ff}) - $signed({1'b0, base_ff});
   assign peak_minus_sus  = $signed({1'b0, peak_ff}) - $signed({1'b0, sus_run_ff});
   assign span_abs        = span_ff[SPAN_W-1] ? SPAN_W'(-span_ff) : SPAN_W'(span_ff);

   // LFO factor: 1 - sine (sine in Q1.15, factor in unsigned Q2.15), or unity with the LFO off
   assign fac_full = $signed((FAC_W+1)'(FAC_ONE)) - (FAC_W+1)'(sin_ff);
   assign fac      = lfo_en_ff ? fac_full[FAC_W-1:0] : FAC_W'(FAC_ONE);

   // ramp end level plus the signed scaled offset, clamped to the level range
   assign quo_s  = $signed(RSUM_W'(div_q));
   assign rend_s = $signed(RSUM_W'(rend_ff));
   assign rsum   = span_ff[SPAN_W-1] ? (rend_s - quo_s) : (rend_s + quo_s);

   always_comb begin
      if (rsum[RSUM_W-1]) begin
         ramp_sat = '0;
      end else if (rsum > $signed(RSUM_W'({LVL_W{1'b1}}))) begin
         ramp_sat = '1;
      end else begin
         ramp_sat = rsum[LVL_W-1:0];
      end
   end

   assign code_raw = mul_p[MUL_P_W-1:DAC_SHIFT];
   assign code_sat = (code_raw > (MUL_P_W-DAC_SHIFT)'(DAC_SAT)) ? DAC_W'(DAC_SAT)
                                                                : code_raw[DAC_W-1:0];

   // feed the shared multiplier by sequencer step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_RMUL: begin
            mul_a = MUL_A_W'(timer_ff);
            mul_b = span_abs[MUL_B_W-1:0];
         end
         S_DMUL1: begin
            mul_a = MUL_A_W'(fac);
            mul_b = MUL_B_W'(DAC_MAX);
         end
         S_DMUL2: begin
            mul_a = mul_p[MUL_A_W-1:0];
            mul_b = level_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      attack_in  = attack_ff;
      decay_in   = decay_ff;
      release_in = release_ff;
      base_in    = base_ff;
      peak_in    = peak_ff;
      sustain_in = sustain_ff;
      lfo_en_in  = lfo_en_ff;
      dual_in    = dual_ff;
      if (csr_accept) begin
         unique case (csr_index)
            CSR_ATTACK:  attack_in  = csr_data[TIME_W-1:0];
            CSR_DECAY:   decay_in   = csr_data[TIME_W-1:0];
            CSR_RELEASE: release_in = csr_data[TIME_W-1:0];
            CSR_BASE:    base_in    = csr_data[LVL_W-1:0];
            CSR_PEAK:    peak_in    = csr_data[LVL_W-1:0];
            CSR_SUSTAIN: sustain_in = csr_data[LVL_W-1:0];
            CSR_LFO:     lfo_en_in  = csr_data[0];
            CSR_DUAL:    dual_in    = csr_data[0];
            default:     ;
         endcase
      end
   end

   // sequencer and envelope update
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      running_in     = running_ff;
      end_pending_in = end_pending_ff;
      mute_in        = mute_ff;
      skip_decay_in  = skip_decay_ff;
      peak_hold_in   = peak_hold_ff;
      timer_in       = timer_ff;
      target_in      = target_ff;
      span_in        = span_ff;
      level_in       = level_ff;
      sus_run_in     = sus_run_ff;
      rend_in        = rend_ff;
      rdur_in        = rdur_ff;
      wr_in          = wr_ff;
      code_in        = code_ff;
      ramp_go        = 1'b0;
      exec_wr        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end

         S_EXEC: begin
            case (cmd_ff) inside
               CMD_TICK: begin
                  if (running_ff) begin
                     if (end_pending_ff && phase_ff != PH_RELEASE) begin
                        // enter release from wherever the level is now
                        phase_in = PH_RELEASE;
                        timer_in = release_ext;
                        span_in  = lvl_minus_base;
                        exec_wr  = lfo_en_ff;
                     end else begin
                        case (phase_ff)
                           PH_START: begin
                              level_in      = base_ff;
                              sus_run_in    = sustain_ff;
                              skip_decay_in = (decay_ext < DECAY_MIN_T);
                              timer_in      = '0;
                              span_in       = peak_minus_base;
                              peak_hold_in  = 1'b0;
                              target_in     = attack_ff;
                              phase_in      = PH_ATTACK;
                              exec_wr       = lfo_en_ff;
                           end
                           PH_ATTACK: begin
                              exec_wr = 1'b1;
                              if (tsum < target_ext) begin
                                 timer_in = tsum;
                                 rend_in  = base_ff;
                                 rdur_in  = target_ff;
                                 ramp_go  = 1'b1;
                              end else begin
                                 level_in = peak_ff;
                                 if (skip_decay_ff) begin
                                    timer_in = '0;
                                    phase_in = PH_SUSTAIN;
                                 end else begin
                                    timer_in  = decay_ext;
                                    phase_in  = PH_DECAY;
                                    span_in   = peak_minus_sus;
                                    target_in = '0;
                                 end
                              end
                           end
                           PH_DECAY: begin
                              exec_wr = 1'b1;
                              if (timer_ff > dt_ext + DECAY_END_T && decay_ff != '0) begin
                                 timer_in = tdiff;
                                 rend_in  = sus_run_ff;
                                 rdur_in  = decay_ff;
                                 ramp_go  = 1'b1;
                              end else begin
                                 level_in = sus_run_ff;
                                 timer_in = '0;
                                 phase_in = PH_SUSTAIN;
                                 if (sus_run_ff >= peak_ff) peak_hold_in = 1'b1;
                              end
                           end
                           PH_SUSTAIN: begin
                              exec_wr = lfo_en_ff;
                              // snap back to peak when sustain sat at or above it, unless dual is set
                              if (peak_hold_ff && level_ff != peak_ff && !dual_ff) begin
                                 level_in = peak_ff;
                                 exec_wr  = 1'b1;
                              end
                           end
                           PH_RELEASE: begin
                              end_pending_in = 1'b0;
                              exec_wr        = 1'b1;
                              if (timer_ff > dt_ext + RELEASE_END_T && release_ff != '0) begin
                                 timer_in = tdiff;
                                 rend_in  = base_ff;
                                 rdur_in  = release_ff;
                                 ramp_go  = 1'b1;
                              end else begin
                                 running_in = 1'b0;
                                 phase_in   = PH_IDLE;
                                 level_in   = base_ff;
                              end
                           end
                           default: begin
                              // running with no phase and no pending end: clear
                              running_in     = 1'b0;
                              end_pending_in = 1'b0;
                              phase_in       = PH_IDLE;
                              level_in       = base_ff;
                              exec_wr        = 1'b1;
                           end
                        endcase
                     end
                  end
               end
               CMD_START: begin
                  if (!running_ff && peak_ff != '0 && !mute_ff) begin
                     running_in = 1'b1;
                     phase_in   = PH_START;
                  end
               end
               CMD_END: begin
                  if (running_ff) begin
                     end_pending_in = 1'b1;
                     phase_in       = PH_IDLE;
                  end
               end
               CMD_MUTE, CMD_UNMUTE: begin
                  mute_in        = (cmd_ff == CMD_MUTE);
                  running_in     = 1'b0;
                  end_pending_in = 1'b0;
                  phase_in       = PH_IDLE;
                  level_in       = base_ff;
                  exec_wr        = 1'b1;
               end
               default: ;
            endcase
            wr_in    = exec_wr;
            code_in  = '0;
            state_in = ramp_go ? S_RMUL : (exec_wr ? S_DMUL1 : S_OUT);
         end

         S_RMUL:  state_in = S_RDIV;
         S_RDIV:  state_in = S_RWAIT;

         S_RWAIT: begin
            if (div_st.done) begin
               level_in = ramp_sat;
               state_in = S_DMUL1;
            end
         end

         S_DMUL1: state_in = S_DMUL2;
         S_DMUL2: state_in = S_CODE;

         S_CODE: begin
            code_in  = code_sat;
            state_in = S_OUT;
         end

         S_OUT: begin
            if (rsp_free) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // output register: load when the finished item finds the slot free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_OUT && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         attack_ff      <= '0;
         decay_ff       <= '0;
         release_ff     <= '0;
         base_ff        <= '0;
         peak_ff        <= '0;
         sustain_ff     <= '0;
         lfo_en_ff      <= 1'b0;
         dual_ff        <= 1'b0;
         phase_ff       <= PH_IDLE;
         running_ff     <= 1'b0;
         end_pending_ff <= 1'b0;
         mute_ff        <= 1'b0;
         skip_decay_ff  <= 1'b0;
         peak_hold_ff   <= 1'b0;
         timer_ff       <= '0;
         target_ff      <= '0;
         span_ff        <= '0;
         level_ff       <= '0;
         sus_run_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         attack_ff      <= attack_in;
         decay_ff       <= decay_in;
         release_ff     <= release_in;
         base_ff        <= base_in;
         peak_ff        <= peak_in;
         sustain_ff     <= sustain_in;
         lfo_en_ff      <= lfo_en_in;
         dual_ff        <= dual_in;
         phase_ff       <= phase_in;
         running_ff     <= running_in;
         end_pending_ff <= end_pending_in;
         mute_ff        <= mute_in;
         skip_decay_ff  <= skip_decay_in;
         peak_hold_ff   <= peak_hold_in;
         timer_ff       <= timer_in;
         target_ff      <= target_in;
         span_ff        <= span_in;
         level_ff       <= level_in;
         sus_run_ff     <= sus_run_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_tuser;
         dt_ff  <= req_tdata[15:0];
         sin_ff <= $signed(req_tdata[31:16]);
      end
      rend_ff <= rend_in;
      rdur_ff <= rdur_in;
      wr_ff   <= wr_in;
      code_ff <= code_in;
      if (state_ff == S_OUT && rsp_free) begin
         rsp_wr_ff     <= wr_ff;
         rsp_code_ff   <= code_ff;
         rsp_active_ff <= running_ff;
         rsp_phase_ff  <= phase_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_phase_ff, rsp_active_ff, rsp_code_ff};
   assign rsp_tuser  = rsp_wr_ff;

   `ADSR_CHECK_NEXT(a_accept_exec, req_accept, state_ff == S_EXEC, "accepted word not decoded")
   `ADSR_CHECK_NOW(a_idle_no_end, !running_ff, !end_pending_ff, "pending end without a running envelope")
   `ADSR_CHECK_NOW(a_wait_div, state_ff == S_RWAIT, div_st.busy || div_st.done, "ramp wait without a division")
   `ADSR_CHECK_NOW(a_nowrite_zero, rsp_valid_ff && !rsp_wr_ff, rsp_code_ff == '0, "code without a write")

endmodule
